// File: hw/rtl/fmmp_pkg.sv
`default_nettype none

package fmmp_pkg;

  // Widths of the item fields.
  localparam int INDEX_BITS = 63;
  localparam int SEED_BITS  = 63;
  localparam int ELEM_BITS  = 30;

  // Derived widths inside the modular multiplier.
  localparam int PROD_BITS     = 2 * ELEM_BITS;
  localparam int Q1_BITS       = ELEM_BITS + 1;
  localparam int QM_BITS       = 2 * Q1_BITS;
  localparam int RED_BITS      = ELEM_BITS + 2;
  localparam int SEED_TOP_BITS = SEED_BITS - PROD_BITS;

  localparam logic [63:0] PRIME_WIDE   = 64'd1000000007;
  localparam logic [63:0] TWO_30_WIDE  = 64'd1 << ELEM_BITS;
  localparam logic [63:0] TWO_60_WIDE  = 64'd1 << PROD_BITS;
  localparam logic [63:0] BARRETT_WIDE = TWO_60_WIDE / PRIME_WIDE;
  localparam logic [63:0] C30_WIDE     = TWO_30_WIDE % PRIME_WIDE;
  localparam logic [63:0] C60_WIDE     = TWO_60_WIDE % PRIME_WIDE;

  localparam logic [ELEM_BITS-1:0] PRIME     = PRIME_WIDE[ELEM_BITS-1:0];
  localparam logic [Q1_BITS-1:0]   BARRETT_M = BARRETT_WIDE[Q1_BITS-1:0];
  localparam logic [ELEM_BITS-1:0] C30       = C30_WIDE[ELEM_BITS-1:0];
  localparam logic [ELEM_BITS-1:0] C60       = C60_WIDE[ELEM_BITS-1:0];

  // Operation slots. For matrix work: bit 3 picks the product (0: acc*base,
  // 1: base*base), bits 2 and 1 pick the row and column, bit 0 the term.
  // For seed work bit 1 picks the seed and bit 0 the term.
  localparam int SLOT_BITS = 4;
  localparam logic [SLOT_BITS-1:0] SLOT_FIRST      = 4'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_SEED_LAST  = 4'd3;
  localparam logic [SLOT_BITS-1:0] SLOT_BASE_FIRST = 4'd8;
  localparam logic [SLOT_BITS-1:0] SLOT_MAT_LAST   = 4'd15;

  typedef enum logic [1:0] {
    KIND_SEED,
    KIND_MAT,
    KIND_FINAL
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [SLOT_BITS-1:0] slot;
  } op_tag_t;

  typedef struct packed {
    logic    load;
    logic    issue;
    op_tag_t tag;
    logic    commit;
  } dp_cmd_t;

  typedef struct packed {
    logic e_zero;
    logic e_lsb;
    logic pipe_empty;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [ELEM_BITS-1:0] e00;
    logic [ELEM_BITS-1:0] e01;
    logic [ELEM_BITS-1:0] e10;
    logic [ELEM_BITS-1:0] e11;
  } mat_t;

  localparam mat_t MAT_Q     = '{e00: 30'd1, e01: 30'd1, e10: 30'd1, e11: 30'd0};
  localparam mat_t MAT_IDENT = '{e00: 30'd1, e01: 30'd0, e10: 30'd0, e11: 30'd1};
  // Makes the final combination return the first seed.
  localparam mat_t MAT_SEL_F0 = '{e00: 30'd0, e01: 30'd0, e10: 30'd1, e11: 30'd0};

  function automatic logic [ELEM_BITS-1:0] mat_pick(mat_t m, logic [1:0] idx);
    logic [ELEM_BITS-1:0] v;
    case (idx)
      2'd0: v = m.e00;
      2'd1: v = m.e01;
      2'd2: v = m.e10;
      default: v = m.e11;
    endcase
    return v;
  endfunction

  function automatic mat_t mat_put(mat_t m, logic [1:0] idx, logic [ELEM_BITS-1:0] v);
    mat_t r;
    r = m;
    case (idx)
      2'd0: r.e00 = v;
      2'd1: r.e01 = v;
      2'd2: r.e10 = v;
      default: r.e11 = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fmmp_in_if.sv
`default_nettype none

interface fmmp_in_if;
  logic                            valid;
  logic                            ready;
  logic [fmmp_pkg::INDEX_BITS-1:0] index_n;
  logic [fmmp_pkg::SEED_BITS-1:0]  first_term;
  logic [fmmp_pkg::SEED_BITS-1:0]  second_term;

  modport source (output valid, output index_n, output first_term, output second_term,
                  input ready);
  modport sink (input valid, input index_n, input first_term, input second_term,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fmmp_out_if.sv
`default_nettype none

interface fmmp_out_if;
  logic                           valid;
  logic                           ready;
  logic [fmmp_pkg::ELEM_BITS-1:0] term_value;

  modport source (output valid, output term_value, input ready);
  modport sink (input valid, input term_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fmmp_mulmod.sv
`default_nettype none

// Pipelined (a * b + c) mod P with Barrett reduction. One operation enters
// per cycle; the result leaves the last pipeline register with its tag.
module fmmp_mulmod (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [fmmp_pkg::ELEM_BITS-1:0] a,
  input  logic [fmmp_pkg::ELEM_BITS-1:0] b,
  input  logic [fmmp_pkg::ELEM_BITS-1:0] c,
  input  fmmp_pkg::op_tag_t              in_tag,
  output logic                           out_valid,
  output logic [fmmp_pkg::ELEM_BITS-1:0] r,
  output fmmp_pkg::op_tag_t              out_tag,
  output logic                           busy
);

  logic v1, v2, v3, v4, v5, v6;
  fmmp_pkg::op_tag_t t1, t2, t3, t4, t5, t6;

  logic [fmmp_pkg::PROD_BITS-1:0] p1;
  logic [fmmp_pkg::ELEM_BITS-1:0] c1;
  logic [fmmp_pkg::PROD_BITS-1:0] x2;
  logic [fmmp_pkg::QM_BITS-1:0]   qm3;
  logic [fmmp_pkg::RED_BITS-1:0]  x3, x4, qp4, r5;
  logic [fmmp_pkg::ELEM_BITS-1:0] r6;

  logic [fmmp_pkg::Q1_BITS-1:0]  q1;
  logic [fmmp_pkg::Q1_BITS-1:0]  q3;
  logic [fmmp_pkg::QM_BITS-1:0]  qp_full;
  logic [fmmp_pkg::RED_BITS-1:0] prime_ext;
  logic [fmmp_pkg::RED_BITS-1:0] prime2_ext;
  logic [fmmp_pkg::RED_BITS-1:0] r_sel;

  assign q1 = x2[fmmp_pkg::PROD_BITS-1:fmmp_pkg::ELEM_BITS-1];
  assign q3 = qm3[fmmp_pkg::QM_BITS-1:fmmp_pkg::Q1_BITS];
  assign qp_full = {{(fmmp_pkg::QM_BITS-fmmp_pkg::Q1_BITS){1'b0}}, q3}
                 * {{(fmmp_pkg::QM_BITS-fmmp_pkg::ELEM_BITS){1'b0}}, fmmp_pkg::PRIME};
  assign prime_ext  = {2'b00, fmmp_pkg::PRIME};
  assign prime2_ext = {1'b0, fmmp_pkg::PRIME, 1'b0};

  // The Barrett estimate is at most two short, so r5 stays below 3P.
  always_comb begin
    if (r5 >= prime2_ext) begin
      r_sel = r5 - prime2_ext;
    end else if (r5 >= prime_ext) begin
      r_sel = r5 - prime_ext;
    end else begin
      r_sel = r5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    t1  <= in_tag;
    p1  <= {{fmmp_pkg::ELEM_BITS{1'b0}}, a} * {{fmmp_pkg::ELEM_BITS{1'b0}}, b};
    c1  <= c;
    t2  <= t1;
    x2  <= p1 + {{fmmp_pkg::ELEM_BITS{1'b0}}, c1};
    t3  <= t2;
    qm3 <= {{(fmmp_pkg::QM_BITS-fmmp_pkg::Q1_BITS){1'b0}}, q1}
         * {{(fmmp_pkg::QM_BITS-fmmp_pkg::Q1_BITS){1'b0}}, fmmp_pkg::BARRETT_M};
    x3  <= x2[fmmp_pkg::RED_BITS-1:0];
    t4  <= t3;
    // Only the low bits matter: the true remainder fits in RED_BITS.
    qp4 <= qp_full[fmmp_pkg::RED_BITS-1:0];
    x4  <= x3;
    t5  <= t4;
    r5  <= x4 - qp4;
    t6  <= t5;
    r6  <= r_sel[fmmp_pkg::ELEM_BITS-1:0];
  end

  assign out_valid = v6;
  assign r         = r6;
  assign out_tag   = t6;
  assign busy      = v1 | v2 | v3 | v4 | v5 | v6;

endmodule

`default_nettype wire

// File: hw/rtl/fmmp_datapath.sv
`default_nettype none

module fmmp_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fmmp_pkg::dp_cmd_t               cmd,
  output fmmp_pkg::dp_stat_t              stat,
  input  logic [fmmp_pkg::INDEX_BITS-1:0] index_n,
  input  logic [fmmp_pkg::SEED_BITS-1:0]  first_term,
  input  logic [fmmp_pkg::SEED_BITS-1:0]  second_term,
  output logic                            res_valid,
  output logic [fmmp_pkg::ELEM_BITS-1:0]  term_value,
  input  logic                            res_ready
);

  logic [fmmp_pkg::INDEX_BITS-1:0] e;
  logic [fmmp_pkg::SEED_BITS-1:0]  first_raw, second_raw;
  logic [fmmp_pkg::ELEM_BITS-1:0]  f0, f1, partial;
  fmmp_pkg::mat_t acc, base, nacc, nbase;

  logic [fmmp_pkg::SEED_BITS-1:0] raw;
  fmmp_pkg::mat_t                 mat_src;
  logic [fmmp_pkg::ELEM_BITS-1:0] op_a, op_b, op_c;

  logic                           mm_valid, mm_busy;
  logic [fmmp_pkg::ELEM_BITS-1:0] mm_r;
  fmmp_pkg::op_tag_t              mm_tag;

  logic [fmmp_pkg::ELEM_BITS:0]   sum_raw;
  logic [fmmp_pkg::ELEM_BITS:0]   sum_red;
  logic [fmmp_pkg::ELEM_BITS-1:0] sum;
  logic                           index_zero;

  assign raw     = cmd.tag.slot[1] ? second_raw : first_raw;
  assign mat_src = cmd.tag.slot[3] ? base : acc;

  // Seeds are folded as hi * 2^60 + mid * 2^30 + lo in two passes through the
  // multiplier; the adder below joins the two partial results.
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    case (cmd.tag.kind)
      fmmp_pkg::KIND_SEED: begin
        if (!cmd.tag.slot[0]) begin
          op_a = raw[fmmp_pkg::PROD_BITS-1:fmmp_pkg::ELEM_BITS];
          op_b = fmmp_pkg::C30;
          op_c = raw[fmmp_pkg::ELEM_BITS-1:0];
        end else begin
          op_a = {{(fmmp_pkg::ELEM_BITS-fmmp_pkg::SEED_TOP_BITS){1'b0}},
                  raw[fmmp_pkg::SEED_BITS-1:fmmp_pkg::PROD_BITS]};
          op_b = fmmp_pkg::C60;
        end
      end
      fmmp_pkg::KIND_MAT: begin
        op_a = fmmp_pkg::mat_pick(mat_src, {cmd.tag.slot[2], cmd.tag.slot[0]});
        op_b = fmmp_pkg::mat_pick(base, {cmd.tag.slot[0], cmd.tag.slot[1]});
      end
      fmmp_pkg::KIND_FINAL: begin
        op_a = cmd.tag.slot[0] ? f0 : f1;
        op_b = cmd.tag.slot[0] ? acc.e10 : acc.e00;
      end
      default: begin
      end
    endcase
  end

  fmmp_mulmod u_mulmod (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.issue),
    .a        (op_a),
    .b        (op_b),
    .c        (op_c),
    .in_tag   (cmd.tag),
    .out_valid(mm_valid),
    .r        (mm_r),
    .out_tag  (mm_tag),
    .busy     (mm_busy)
  );

  assign sum_raw = {1'b0, partial} + {1'b0, mm_r};
  assign sum_red = (sum_raw >= {1'b0, fmmp_pkg::PRIME}) ?
                   sum_raw - {1'b0, fmmp_pkg::PRIME} : sum_raw;
  assign sum     = sum_red[fmmp_pkg::ELEM_BITS-1:0];

  assign index_zero = (index_n == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_raw  <= first_term;
      second_raw <= second_term;
      base       <= fmmp_pkg::MAT_Q;
      acc        <= index_zero ? fmmp_pkg::MAT_SEL_F0 : fmmp_pkg::MAT_IDENT;
      e          <= index_zero ? '0 :
                    index_n - {{(fmmp_pkg::INDEX_BITS-1){1'b0}}, 1'b1};
    end
    if (cmd.commit) begin
      if (e[0]) begin
        acc <= nacc;
      end
      base <= nbase;
      e    <= e >> 1;
    end
    if (mm_valid) begin
      if (!mm_tag.slot[0]) begin
        partial <= mm_r;
      end else begin
        case (mm_tag.kind)
          fmmp_pkg::KIND_SEED: begin
            if (mm_tag.slot[1]) begin
              f1 <= sum;
            end else begin
              f0 <= sum;
            end
          end
          fmmp_pkg::KIND_MAT: begin
            if (mm_tag.slot[3]) begin
              nbase <= fmmp_pkg::mat_put(nbase, {mm_tag.slot[2], mm_tag.slot[1]}, sum);
            end else begin
              nacc <= fmmp_pkg::mat_put(nacc, {mm_tag.slot[2], mm_tag.slot[1]}, sum);
            end
          end
          fmmp_pkg::KIND_FINAL: begin
            term_value <= sum;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The controller only starts a final combination when this register is
  // free, so a write never meets a waiting result.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (mm_valid && mm_tag.slot[0] && mm_tag.kind == fmmp_pkg::KIND_FINAL) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign stat.e_zero     = (e == '0);
  assign stat.e_lsb      = e[0];
  assign stat.pipe_empty = !mm_busy;
  assign stat.out_free   = !res_valid;

endmodule

`default_nettype wire

// File: hw/rtl/fmmp_ctrl.sv
`default_nettype none

module fmmp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fmmp_pkg::dp_stat_t stat,
  output fmmp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINAL0,
    ST_FINAL1
  } state_t;

  state_t                         state;
  logic [fmmp_pkg::SLOT_BITS-1:0] slot;
  logic                           final_go;

  assign final_go = stat.pipe_empty && stat.out_free;

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.tag.slot = slot;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SEED: begin
        cmd.issue    = 1'b1;
        cmd.tag.kind = fmmp_pkg::KIND_SEED;
      end
      ST_ISSUE: begin
        cmd.issue    = 1'b1;
        cmd.tag.kind = fmmp_pkg::KIND_MAT;
      end
      ST_DRAIN: begin
        cmd.commit = stat.pipe_empty;
      end
      ST_FINAL0: begin
        cmd.issue    = final_go;
        cmd.tag.kind = fmmp_pkg::KIND_FINAL;
      end
      ST_FINAL1: begin
        cmd.issue    = 1'b1;
        cmd.tag.kind = fmmp_pkg::KIND_FINAL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= fmmp_pkg::SLOT_FIRST;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SEED;
            slot  <= fmmp_pkg::SLOT_FIRST;
          end
        end
        ST_SEED: begin
          if (slot == fmmp_pkg::SLOT_SEED_LAST) begin
            state <= ST_CHECK;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        ST_CHECK: begin
          if (stat.e_zero) begin
            state <= ST_FINAL0;
            slot  <= fmmp_pkg::SLOT_FIRST;
          end else begin
            state <= ST_ISSUE;
            // With a clear exponent bit only the squaring of base is needed.
            slot  <= stat.e_lsb ? fmmp_pkg::SLOT_FIRST : fmmp_pkg::SLOT_BASE_FIRST;
          end
        end
        ST_ISSUE: begin
          if (slot == fmmp_pkg::SLOT_MAT_LAST) begin
            state <= ST_DRAIN;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (stat.pipe_empty) begin
            state <= ST_CHECK;
          end
        end
        ST_FINAL0: begin
          if (final_go) begin
            state <= ST_FINAL1;
            slot  <= slot + 1'b1;
          end
        end
        ST_FINAL1: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fibonacci_mod_matrix_power_unit.sv
`default_nettype none

// Computes term index_n of the sequence that starts first_term, second_term and
// adds the two previous terms, modulo 1000000007, by square-and-multiply on the
// matrix [[1,1],[1,0]]. All modular products go through one six-stage pipelined
// (a*b + c) mod P unit, so the run time follows the exponent n-1: for each of
// its significant bits there is a check, the issue of the products for the
// squaring plus those for the multiply when the bit is set, and a drain of the
// pipeline; before the loop the seeds are reduced, after it comes the final
// combination. One item is worked on at a time; the finished result sits in an
// output register while the next item is taken and worked on.
module fibonacci_mod_matrix_power_unit (
  input  logic              clk,
  input  logic              rst,
  fmmp_in_if.sink           item,
  fmmp_out_if.source        result
);

  fmmp_pkg::dp_cmd_t  cmd;
  fmmp_pkg::dp_stat_t stat;

  fmmp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(item.valid),
    .in_ready(item.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  fmmp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .index_n    (item.index_n),
    .first_term (item.first_term),
    .second_term(item.second_term),
    .res_valid  (result.valid),
    .term_value (result.term_value),
    .res_ready  (result.ready)
  );

endmodule

`default_nettype wire

// File: hw/rtl/fmmp_checker.sv
`default_nettype none

module fmmp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [fmmp_pkg::ELEM_BITS-1:0] term_value
);

  // Items taken but whose result has not been transferred yet.
  logic [1:0] pending;
  logic       item_xfer;
  logic       result_xfer;

  assign item_xfer   = item_valid && item_ready;
  assign result_xfer = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (item_xfer && !result_xfer) begin
      pending <= pending + 2'd1;
    end else if (result_xfer && !item_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(term_value))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> term_value < fmmp_pkg::PRIME)
    else $error("term_value not reduced below the modulus");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result offered with no item outstanding");

  assert property (@(posedge clk) disable iff (rst)
    item_ready |-> pending <= 2'd1)
    else $error("new item taken while two are already outstanding");

endmodule

bind fibonacci_mod_matrix_power_unit fmmp_checker u_fmmp_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .term_value  (result.term_value)
);

`default_nettype wire

// File: sim/fibonacci_mod_matrix_power_unit_tb.sv
`timescale 1ns / 100ps

module fibonacci_mod_matrix_power_unit_tb;

  localparam int INDEX_BITS = fmmp_pkg::INDEX_BITS;
  localparam int SEED_BITS = fmmp_pkg::SEED_BITS;
  localparam int ELEM_BITS = fmmp_pkg::ELEM_BITS;
  localparam logic [63:0] PRIME_WIDE = fmmp_pkg::PRIME_WIDE;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 1600;
  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [62:0] P63 = 63'd1000000007;

  typedef struct packed {
    logic [INDEX_BITS-1:0] n;
    logic [SEED_BITS-1:0]  s0;
    logic [SEED_BITS-1:0]  s1;
    logic                  typed;
    logic [ELEM_BITS-1:0]  term;
  } stim_row_t;

  typedef struct packed {
    logic [ELEM_BITS-1:0] m00;
    logic [ELEM_BITS-1:0] m01;
    logic [ELEM_BITS-1:0] m10;
    logic [ELEM_BITS-1:0] m11;
  } mod_mat_t;

  localparam int NUM_ROWS = 23;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{63'd0, 63'd0, 63'd1, 1'b1, 30'd0},
    '{63'd1, 63'd0, 63'd1, 1'b1, 30'd1},
    '{63'd2, 63'd0, 63'd1, 1'b1, 30'd1},
    '{63'd10, 63'd0, 63'd1, 1'b1, 30'd55},
    '{63'd40, 63'd0, 63'd1, 1'b1, 30'd102334155},
    '{63'd45, 63'd0, 63'd1, 1'b1, 30'd134903163},
    '{63'd2, 63'd3, 63'd4, 1'b1, 30'd7},
    '{63'd3, 63'd3, 63'd4, 1'b1, 30'd11},
    '{63'd3, 63'd0, 63'd0, 1'b1, 30'd0},
    '{63'd0, P63, 63'd5, 1'b1, 30'd0},
    '{63'd1, 63'd5, P63, 1'b1, 30'd0},
    '{63'd0, P63 - 63'd1, 63'd0, 1'b1, 30'd1000000006},
    '{63'd0, P63 + 63'd5, 63'd0, 1'b1, 30'd5},
    '{63'd1, 63'd0, MAX63, 1'b0, 30'd0},
    '{63'd0, MAX63, MAX63, 1'b0, 30'd0},
    '{63'd2, MAX63, MAX63, 1'b0, 30'd0},
    '{MAX63, 63'd0, 63'd1, 1'b0, 30'd0},
    '{MAX63, MAX63, MAX63, 1'b0, 30'd0},
    '{63'd1 << 62, 63'd7, 63'd9, 1'b0, 30'd0},
    '{(63'd1 << 62) + 63'd1, MAX63, 63'd0, 1'b0, 30'd0},
    '{{{31{2'b01}}, 1'b1}, {{31{2'b10}}, 1'b0}, {{31{2'b01}}, 1'b1}, 1'b0, 30'd0},
    '{{{31{2'b10}}, 1'b0}, {{31{2'b01}}, 1'b1}, {{31{2'b10}}, 1'b0}, 1'b0, 30'd0},
    '{P63, 63'd1, 63'd1, 1'b0, 30'd0}
  };

  logic clk = 1'b1;
  logic rst;

  fmmp_in_if in_ch();
  fmmp_out_if out_ch();

  fibonacci_mod_matrix_power_unit uut (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .result(out_ch)
  );

  logic [ELEM_BITS-1:0] expected_terms [$];
  logic                 row_typed;
  logic [ELEM_BITS-1:0] row_term;
  int                   errors = 0;
  int                   terms_seen = 0;
  int                   idle_cycles = 0;
  bit                   steady = 1'b0;

  always begin
    #2 clk = 1'b0;
    #2 clk = 1'b1;
  end

  function automatic logic [ELEM_BITS-1:0] mul_mod(logic [ELEM_BITS-1:0] a,
                                                    logic [ELEM_BITS-1:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return ELEM_BITS'(p % PRIME_WIDE);
  endfunction

  function automatic logic [ELEM_BITS-1:0] add_mod(logic [ELEM_BITS-1:0] a,
                                                    logic [ELEM_BITS-1:0] b);
    return ELEM_BITS'((64'(a) + 64'(b)) % PRIME_WIDE);
  endfunction

  function automatic mod_mat_t mat_product(mod_mat_t x, mod_mat_t y);
    mod_mat_t r;
    r.m00 = add_mod(mul_mod(x.m00, y.m00), mul_mod(x.m01, y.m10));
    r.m01 = add_mod(mul_mod(x.m00, y.m01), mul_mod(x.m01, y.m11));
    r.m10 = add_mod(mul_mod(x.m10, y.m00), mul_mod(x.m11, y.m10));
    r.m11 = add_mod(mul_mod(x.m10, y.m01), mul_mod(x.m11, y.m11));
    return r;
  endfunction

  // Term n of the sequence seeded with s0, s1, reduced mod the prime.
  function automatic logic [ELEM_BITS-1:0] seq_term_mod(logic [INDEX_BITS-1:0] n,
                                                         logic [SEED_BITS-1:0] s0,
                                                         logic [SEED_BITS-1:0] s1);
    logic [ELEM_BITS-1:0]  f0;
    logic [ELEM_BITS-1:0]  f1;
    logic [INDEX_BITS-1:0] e;
    mod_mat_t              sq;
    mod_mat_t              acc;
    f0 = ELEM_BITS'(64'(s0) % PRIME_WIDE);
    f1 = ELEM_BITS'(64'(s1) % PRIME_WIDE);
    if (n == '0)
      return f0;
    if (n == INDEX_BITS'(1))
      return f1;
    sq = '{m00: 30'd1, m01: 30'd1, m10: 30'd1, m11: 30'd0};
    acc = '{m00: 30'd1, m01: 30'd0, m10: 30'd0, m11: 30'd1};
    e = n - INDEX_BITS'(1);
    while (e != '0) begin
      if (e[0])
        acc = mat_product(acc, sq);
      sq = mat_product(sq, sq);
      e = e >> 1;
    end
    return add_mod(mul_mod(f1, acc.m00), mul_mod(f0, acc.m10));
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // Small indices keep the run short; a tenth of the items are wider than 40 bits, half of those at the full width.
  function automatic logic [INDEX_BITS-1:0] pick_index();
    int unsigned r;
    int unsigned w;
    logic [62:0] v;
    r = $urandom_range(0, 99);
    v = rand63();
    if (r < 10)
      return {62'd0, v[0]};
    if (r < 65)
      w = $urandom_range(2, 12);
    else if (r < 90)
      w = $urandom_range(13, 40);
    else
      w = $urandom_range(0, 1) ? 63 : $urandom_range(41, 62);
    return v & ((63'd1 << w) - 63'd1);
  endfunction

  function automatic logic [SEED_BITS-1:0] pick_seed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return rand63();
    if (r < 60)
      return 63'($urandom_range(0, 99));
    if (r < 80)
      return P63 * 63'($urandom_range(1, 1 << 20)) + 63'($urandom_range(0, 2)) - 63'd1;
    return 63'($urandom_range(0, 32'h3FFF_FFFF));
  endfunction

  task automatic offer(input logic [INDEX_BITS-1:0] n, input logic [SEED_BITS-1:0] s0,
                       input logic [SEED_BITS-1:0] s1, input logic typed,
                       input logic [ELEM_BITS-1:0] term);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.index_n <= n;
    in_ch.first_term <= s0;
    in_ch.second_term <= s1;
    row_typed <= typed;
    row_term <= term;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Scoreboard: predictions are queued at each input transfer and matched in order.
  always @(posedge clk) begin
    logic [ELEM_BITS-1:0] want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        terms_seen++;
        if (expected_terms.size() == 0) begin
          errors++;
          $error("term_value: no result expected, got %0d", out_ch.term_value);
        end else begin
          want = expected_terms.pop_front();
          if (out_ch.term_value !== want) begin
            errors++;
            $error("term_value: expected %0d, got %0d", want, out_ch.term_value);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_terms.push_back(row_typed ? row_term :
                                 seq_term_mod(in_ch.index_n, in_ch.first_term,
                                              in_ch.second_term));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off so the block fills up.
  initial begin
    bit held;
    int len;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && terms_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, steady ? 400 : 6)) @(posedge clk);
      len = steady ? 0 : idle_len();
      if (len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.index_n <= '0;
    in_ch.first_term <= '0;
    in_ch.second_term <= '0;
    row_typed <= 1'b0;
    row_term <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      offer(DIRECTED_ROWS[i].n, DIRECTED_ROWS[i].s0, DIRECTED_ROWS[i].s1,
            DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].term);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 50 == 0)
        steady = ($urandom_range(0, 3) == 0);
      offer(pick_index(), pick_seed(), pick_seed(), 1'b0, '0);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fmmp_pkg.sv
hw/rtl/fmmp_in_if.sv
hw/rtl/fmmp_out_if.sv
hw/rtl/fmmp_mulmod.sv
hw/rtl/fmmp_datapath.sv
hw/rtl/fmmp_ctrl.sv
hw/rtl/fibonacci_mod_matrix_power_unit.sv
hw/rtl/fmmp_checker.sv
sim/fibonacci_mod_matrix_power_unit_tb.sv
